// ===== rtl/core/sps_pkg.sv =====
// Shared constants, types and helpers for the stepper phase sequencer.
// No dependencies; imported by stepper_phase_sequencer_unit.
`timescale 1ns / 1ps

package sps_pkg;

    // Field widths
    localparam int MODE_W  = 2;
    localparam int SPEED_W = 12;
    localparam int PHASE_W = 2;

    // Rate limits and mm/s scale (1288 / 129 = 9)
    localparam int MAX_RATE    = 1288;
    localparam int MM_S_FULL   = 129;
    localparam int MM_S_SCALE  = MAX_RATE / MM_S_FULL;
    localparam int PHASE_COUNT = 4;

    // Countdown / quotient width and divider iteration counter width
    localparam int CNT_W  = $clog2(MAX_RATE + 1);
    localparam int ITER_W = $clog2(CNT_W);

    // Widened product width for the mm/s scaling
    localparam int PROD_W = SPEED_W + 5;

    // Input mode codes
    localparam logic [MODE_W-1:0] MODE_TICK    = 2'd0;
    localparam logic [MODE_W-1:0] MODE_SET_MM  = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SET_RAW = 2'd2;

    // Controller states, one-hot
    typedef enum logic [1:0] {
        ST_IDLE = 2'b01,
        ST_DIV  = 2'b10
    } t_state;

    typedef struct packed {
        logic a;
        logic b;
        logic c;
        logic d;
    } t_coils;

    // Full-step coil pattern per phase
    function automatic t_coils coil_pattern(input logic [PHASE_W-1:0] phase);
        t_coils pat;
        unique case (phase)
            2'd0:    pat = '{a: 1'b0, b: 1'b1, c: 1'b1, d: 1'b0};
            2'd1:    pat = '{a: 1'b1, b: 1'b0, c: 1'b1, d: 1'b0};
            2'd2:    pat = '{a: 1'b1, b: 1'b0, c: 1'b0, d: 1'b1};
            default: pat = '{a: 1'b0, b: 1'b1, c: 1'b0, d: 1'b1};
        endcase
        return pat;
    endfunction

    // Saturate a widened signed rate to +-MAX_RATE
    function automatic logic signed [SPEED_W-1:0] clamp_rate(
        input logic signed [PROD_W-1:0] r
    );
        logic signed [SPEED_W-1:0] res;
        if (r > $signed(PROD_W'(MAX_RATE))) begin
            res = $signed(SPEED_W'(MAX_RATE));
        end else if (r < -$signed(PROD_W'(MAX_RATE))) begin
            res = -$signed(SPEED_W'(MAX_RATE));
        end else begin
            res = r[SPEED_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/core/stepper_phase_sequencer_unit.sv =====
// Stepper phase sequencer top level: speed set, countdown, phase stepping.
// Depends on sps_pkg; contains a bit-serial restoring divider for the reload.
`timescale 1ns / 1ps
//
//  channel   direction  signals                               handshake
//  ------    ---------  ------------------------------------  -------------------
//  input     in         i_mode, i_speed_value                 i_valid / o_ready
//  result    out        o_coil_a..d, o_phase_index, o_stepped  o_valid / i_ready
//
//  A tick (or unused mode) is handled directly in the idle state. For a speed
//  set, the reload value MAX_RATE / |rate| is formed one quotient bit per
//  cycle by the serial divider, during which o_ready is low.
//  Reset clears phase, countdown and rate; the first result shows phase 0.
//  A held result (i_ready low) blocks new input transactions until taken.

module stepper_phase_sequencer_unit (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [sps_pkg::MODE_W-1:0]   i_mode,
    input  logic signed [sps_pkg::SPEED_W-1:0] i_speed_value,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic                         o_coil_a,
    output logic                         o_coil_b,
    output logic                         o_coil_c,
    output logic                         o_coil_d,
    output logic [sps_pkg::PHASE_W-1:0]  o_phase_index,
    output logic                         o_stepped
);
    import sps_pkg::*;

    t_state                      r_state, n_state;
    logic [PHASE_W-1:0]          r_phase, n_phase;
    logic [CNT_W-1:0]            r_count, n_count;
    logic signed [SPEED_W-1:0]   r_rate, n_rate;
    logic [CNT_W-1:0]            r_mag, n_mag;
    logic [CNT_W-1:0]            r_quot, n_quot;
    logic [CNT_W-1:0]            r_rem, n_rem;
    logic [ITER_W-1:0]           r_iter, n_iter;
    logic                        r_out_valid, n_out_valid;
    logic [PHASE_W-1:0]          r_out_phase, n_out_phase;
    logic                        r_out_step, n_out_step;

    logic                        accept;
    logic signed [PROD_W-1:0]    speed_ext;
    logic signed [PROD_W-1:0]    speed_scaled;
    logic signed [SPEED_W-1:0]   rate_new;
    logic [SPEED_W-1:0]          rate_neg;
    logic [CNT_W:0]              trial;
    logic [CNT_W:0]              trial_diff;
    t_coils                      coils;

    assign o_ready = (r_state == ST_IDLE) && (!r_out_valid || i_ready);
    assign accept  = i_valid && o_ready;

    // mm/s scaling by 9 as shift and add, then saturation
    assign speed_ext    = PROD_W'(i_speed_value);
    assign speed_scaled = (speed_ext <<< 3) + speed_ext;
    always_comb begin
        if (i_mode == MODE_SET_MM) begin
            rate_new = clamp_rate(speed_scaled);
        end else begin
            rate_new = clamp_rate(speed_ext);
        end
    end
    assign rate_neg = SPEED_W'(-rate_new);

    // Restoring divider step: one quotient bit per cycle
    assign trial      = {r_rem, r_quot[CNT_W-1]};
    assign trial_diff = trial - {1'b0, r_mag};

    always_comb begin
        n_state     = r_state;
        n_phase     = r_phase;
        n_count     = r_count;
        n_rate      = r_rate;
        n_mag       = r_mag;
        n_quot      = r_quot;
        n_rem       = r_rem;
        n_iter      = r_iter;
        n_out_valid = r_out_valid;
        n_out_phase = r_out_phase;
        n_out_step  = r_out_step;

        if (o_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_out_valid = 1'b1;
                    n_out_step  = 1'b0;
                    n_out_phase = r_phase;
                    priority if (i_mode == MODE_SET_MM || i_mode == MODE_SET_RAW) begin
                        // new rate; reload value is computed serially
                        n_rate  = rate_new;
                        n_mag   = rate_new[SPEED_W-1] ? rate_neg[CNT_W-1:0]
                                                      : rate_new[CNT_W-1:0];
                        n_quot  = CNT_W'(MAX_RATE);
                        n_rem   = '0;
                        n_iter  = '0;
                        n_state = ST_DIV;
                    end else if (i_mode == MODE_TICK && r_rate != '0) begin
                        if (r_count <= CNT_W'(1)) begin
                            // expired: step and reload (r_quot holds the reload)
                            n_phase = r_rate[SPEED_W-1] ? r_phase - PHASE_W'(1)
                                                        : r_phase + PHASE_W'(1);
                            n_count     = r_quot;
                            n_out_phase = n_phase;
                            n_out_step  = 1'b1;
                        end else begin
                            n_count = r_count - CNT_W'(1);
                        end
                    end else begin
                        // stopped tick or unused mode: hold
                        n_out_step = 1'b0;
                    end
                end
            end
            ST_DIV: begin
                if (!trial_diff[CNT_W]) begin
                    n_rem  = trial_diff[CNT_W-1:0];
                    n_quot = {r_quot[CNT_W-2:0], 1'b1};
                end else begin
                    n_rem  = trial[CNT_W-1:0];
                    n_quot = {r_quot[CNT_W-2:0], 1'b0};
                end
                n_iter = r_iter + ITER_W'(1);
                if (r_iter == ITER_W'(CNT_W - 1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_phase     <= '0;
            r_count     <= '0;
            r_rate      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_rate      <= n_rate;
            r_out_valid <= n_out_valid;
        end
    end

    // Divider datapath and result payload
    always_ff @(posedge i_clk) begin
        r_mag       <= n_mag;
        r_quot      <= n_quot;
        r_rem       <= n_rem;
        r_iter      <= n_iter;
        r_out_phase <= n_out_phase;
        r_out_step  <= n_out_step;
    end

    // Result outputs
    assign coils         = coil_pattern(r_out_phase);
    assign o_valid       = r_out_valid;
    assign o_coil_a      = coils.a;
    assign o_coil_b      = coils.b;
    assign o_coil_c      = coils.c;
    assign o_coil_d      = coils.d;
    assign o_phase_index = r_out_phase;
    assign o_stepped     = r_out_step;

endmodule
